/* sv/dpfr_pkg.sv */
// Shared constants, port widths and controller/datapath interface types for the frame replacer.
`timescale 1ns / 1ps

package dpfr_pkg;

  localparam int DEF_MAX_PAGES  = 256;
  localparam int DEF_MAX_FRAMES = 64;
  localparam int SCAN_LANES     = 8;

  localparam int PAGE_W        = 8;
  localparam int FRAME_OUT_W   = 6;
  localparam int EVPAGE_W      = 8;
  localparam int PAGE_COUNT_W  = 9;
  localparam int FRAME_COUNT_W = 7;
  localparam int PID_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int S_DATA_W      = 8;
  localparam int M_DATA_W      = 24;
  localparam int M_PAD_W       = M_DATA_W - (1 + FRAME_OUT_W + 1 + EVPAGE_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_ID  = 2'd2;

  localparam logic [PAGE_COUNT_W-1:0]  PAGE_COUNT_RST  = 9'd256;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 7'd64;
  localparam logic [PID_W-1:0]         PID_RST         = 8'd0;

  typedef struct packed {
    logic accept;
    logic set_oor;
    logic set_hit;
    logic start_free;
    logic start_vict;
    logic step;
    logic rd_victim;
    logic set_nofr;
    logic load;
    logic push;
  } dpfr_cmd_t;

  typedef struct packed {
    logic oor;
    logic hit;
    logic can_free;
    logic found;
    logic last;
    logic out_full;
  } dpfr_stat_t;

endpackage

/* sv/dpfr_ctrl.sv */
// Sequencing state machine for lookup, free-frame scan, victim scan, load and response.
`timescale 1ns / 1ps

module dpfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dpfr_pkg::dpfr_stat_t stat_i,
  output dpfr_pkg::dpfr_cmd_t  cmd_o
);
  import dpfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FSCAN,
    ST_VSCAN,
    ST_VREAD,
    ST_LOAD,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat_i.oor) begin
          cmd_o.set_oor = 1'b1;
          state_d       = ST_RESP;
        end else if (stat_i.hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_RESP;
        end else if (stat_i.can_free) begin
          cmd_o.start_free = 1'b1;
          state_d          = ST_FSCAN;
        end else begin
          cmd_o.start_vict = 1'b1;
          state_d          = ST_VSCAN;
        end
      end
      ST_FSCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.found) begin
          state_d = ST_LOAD;
        end else if (stat_i.last) begin
          cmd_o.start_vict = 1'b1;
          state_d          = ST_VSCAN;
        end
      end
      ST_VSCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.found) begin
          state_d = ST_VREAD;
        end else if (stat_i.last) begin
          cmd_o.set_nofr = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_VREAD: begin
        cmd_o.rd_victim = 1'b1;
        state_d         = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (!stat_i.out_full) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/dpfr_dp.sv */
// Datapath: page table, frame busy bits, counters, eight-lane rotating scan and output register.
`timescale 1ns / 1ps

module dpfr_dp #(
  parameter int MAX_PAGES  = dpfr_pkg::DEF_MAX_PAGES,
  parameter int MAX_FRAMES = dpfr_pkg::DEF_MAX_FRAMES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dpfr_pkg::dpfr_cmd_t               cmd_i,
  output dpfr_pkg::dpfr_stat_t              stat_o,
  input  logic [dpfr_pkg::S_DATA_W-1:0]     in_data_i,
  input  logic                              cfg_we_i,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [dpfr_pkg::M_DATA_W-1:0]     out_data_o
);
  import dpfr_pkg::*;

  localparam int PW   = $clog2(MAX_PAGES);
  localparam int PCW  = $clog2(MAX_PAGES + 1);
  localparam int FW   = $clog2(MAX_FRAMES);
  localparam int HW   = $clog2(MAX_FRAMES + 1);
  localparam int MAXN = (MAX_PAGES > MAX_FRAMES) ? MAX_PAGES : MAX_FRAMES;
  localparam int NW   = $clog2(MAXN + 1);
  localparam int CW   = NW + 4;
  localparam int CMPW = (PCW > PAGE_W) ? PCW : PAGE_W;
  localparam int IXW  = PW + PAGE_W;
  localparam int FXW  = FW + FRAME_OUT_W;
  localparam int VXW  = PW + EVPAGE_W;

  logic [PAGE_COUNT_W-1:0]  page_count_q;
  logic [FRAME_COUNT_W-1:0] frame_count_q;
  logic [PID_W-1:0]         pid_q;

  logic [MAX_PAGES-1:0]  valid_q;
  logic [MAX_FRAMES-1:0] busy_q;
  logic [HW-1:0]         fiu_q;
  logic [HW-1:0]         hint_q;
  logic [PW-1:0]         vp_q;
  logic [NW-1:0]         cur_q;
  logic [NW-1:0]         rem_q;
  logic                  mode_q;
  logic                  ev_q;
  logic                  out_valid_q;

  logic [PAGE_W-1:0]     page_q;
  logic [FW-1:0]         fr_q;
  logic [PW-1:0]         victim_q;
  logic [FW-1:0]         rd_data_q;
  logic                  res_fault_q;
  logic [FRAME_OUT_W-1:0] res_frame_q;
  logic                  res_ev_q;
  logic [EVPAGE_W-1:0]   res_evpage_q;
  logic                  res_status_q;
  logic [M_DATA_W-1:0]   out_data_q;

  logic [FW-1:0]    pf_mem [MAX_PAGES];
  logic [PID_W-1:0] owner_mem [MAX_FRAMES];

  logic [PCW-1:0] np;
  logic [HW-1:0]  nf;
  logic [HW-1:0]  hint_norm;
  logic [PW-1:0]  vp_norm;
  logic [NW-1:0]  scan_n;
  logic [IXW-1:0] in_px;
  logic [IXW-1:0] page_px;
  logic [PW-1:0]  in_page_idx;
  logic [PW-1:0]  page_idx;
  logic [PW-1:0]  rd_addr;
  logic           rd_en;
  logic [FW-1:0]  frame_sel;
  logic [FXW-1:0] hit_fx;
  logic [FXW-1:0] sel_fx;
  logic [VXW-1:0] victim_vx;
  logic           oor;

  logic [CW-1:0]         lane_sum [SCAN_LANES];
  logic [SCAN_LANES-1:0] lane_hit;
  logic                  scan_found;
  logic [NW-1:0]         scan_idx;
  logic                  scan_last;
  logic [CW-1:0]         cur_adv;
  logic [CW-1:0]         rem_adv;
  logic [CW-1:0]         idx_inc;
  logic [PW-1:0]         vp_next;
  logic [HW-1:0]         fiu_load;
  logic                  found_free;
  logic                  found_page;

  assign np = (page_count_q == '0) ? PCW'(1) :
              (32'(page_count_q) > 32'(MAX_PAGES)) ? PCW'(MAX_PAGES) : PCW'(page_count_q);
  assign nf = (frame_count_q == '0) ? HW'(1) :
              (32'(frame_count_q) > 32'(MAX_FRAMES)) ? HW'(MAX_FRAMES) : HW'(frame_count_q);

  assign hint_norm = (hint_q >= nf) ? '0 : hint_q;
  assign vp_norm   = (PCW'(vp_q) >= np) ? '0 : vp_q;
  assign scan_n    = mode_q ? NW'(np) : NW'(nf);

  assign in_px       = IXW'(in_data_i[PAGE_W-1:0]);
  assign page_px     = IXW'(page_q);
  assign in_page_idx = in_px[PW-1:0];
  assign page_idx    = page_px[PW-1:0];

  assign oor       = CMPW'(page_q) >= CMPW'(np);
  assign frame_sel = ev_q ? rd_data_q : fr_q;
  assign hit_fx    = FXW'(rd_data_q);
  assign sel_fx    = FXW'(frame_sel);
  assign victim_vx = VXW'(victim_q);

  assign rd_en   = cmd_i.accept | cmd_i.rd_victim;
  assign rd_addr = cmd_i.accept ? in_page_idx : victim_q;

  // Scan up to eight consecutive indices of the circular range per cycle.
  always_comb begin
    for (int k = 0; k < SCAN_LANES; k++) begin
      lane_sum[k] = CW'(cur_q) + CW'(k);
      if (lane_sum[k] >= CW'(scan_n)) begin
        lane_sum[k] = lane_sum[k] - CW'(scan_n);
      end
      lane_hit[k] = (CW'(k) < CW'(rem_q)) &&
                    (mode_q ? valid_q[lane_sum[k][PW-1:0]] : !busy_q[lane_sum[k][FW-1:0]]);
    end
  end

  always_comb begin
    scan_found = 1'b0;
    scan_idx   = '0;
    for (int k = SCAN_LANES - 1; k >= 0; k--) begin
      if (lane_hit[k]) begin
        scan_found = 1'b1;
        scan_idx   = lane_sum[k][NW-1:0];
      end
    end
  end

  always_comb begin
    cur_adv = CW'(cur_q) + CW'(SCAN_LANES);
    if (cur_adv >= CW'(scan_n)) begin
      cur_adv = cur_adv - CW'(scan_n);
    end
  end

  assign rem_adv    = CW'(rem_q) - CW'(SCAN_LANES);
  assign scan_last  = CW'(rem_q) <= CW'(SCAN_LANES);
  assign idx_inc    = CW'(scan_idx) + CW'(1);
  assign vp_next    = (idx_inc == CW'(np)) ? '0 : idx_inc[PW-1:0];
  assign found_free = cmd_i.step & scan_found & !mode_q;
  assign found_page = cmd_i.step & scan_found & mode_q;
  assign fiu_load   = (ev_q && fiu_q != '0) ? fiu_q : fiu_q + HW'(1);

  assign stat_o.oor      = oor;
  assign stat_o.hit      = !oor & valid_q[page_idx];
  assign stat_o.can_free = fiu_q < nf;
  assign stat_o.found    = scan_found;
  assign stat_o.last     = scan_last;
  assign stat_o.out_full = out_valid_q & !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q  <= PAGE_COUNT_RST;
      frame_count_q <= FRAME_COUNT_RST;
      pid_q         <= PID_RST;
      valid_q       <= '0;
      busy_q        <= '0;
      fiu_q         <= '0;
      hint_q        <= '0;
      vp_q          <= '0;
      cur_q         <= '0;
      rem_q         <= '0;
      mode_q        <= 1'b0;
      ev_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PAGE_COUNT:  page_count_q  <= cfg_data_i[PAGE_COUNT_W-1:0];
          CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[FRAME_COUNT_W-1:0];
          CFG_PROCESS_ID:  pid_q         <= cfg_data_i[PID_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        ev_q <= 1'b0;
      end
      if (found_free) begin
        hint_q <= idx_inc[HW-1:0];
      end
      if (found_page) begin
        vp_q <= vp_next;
        ev_q <= 1'b1;
      end
      if (cmd_i.start_free) begin
        hint_q <= hint_norm;
        cur_q  <= NW'(hint_norm);
        rem_q  <= NW'(nf);
        mode_q <= 1'b0;
      end else if (cmd_i.start_vict) begin
        vp_q   <= vp_norm;
        cur_q  <= NW'(vp_norm);
        rem_q  <= NW'(np);
        mode_q <= 1'b1;
      end else if (cmd_i.step && !scan_found && !scan_last) begin
        cur_q <= cur_adv[NW-1:0];
        rem_q <= rem_adv[NW-1:0];
      end
      if (cmd_i.load) begin
        if (ev_q) begin
          valid_q[victim_q] <= 1'b0;
        end
        valid_q[page_idx]  <= 1'b1;
        busy_q[frame_sel]  <= 1'b1;
        fiu_q              <= fiu_load;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= in_data_i[PAGE_W-1:0];
    end
    if (found_free) begin
      fr_q <= scan_idx[FW-1:0];
    end
    if (found_page) begin
      victim_q <= scan_idx[PW-1:0];
    end
    if (cmd_i.set_oor) begin
      res_fault_q  <= 1'b0;
      res_frame_q  <= '0;
      res_ev_q     <= 1'b0;
      res_evpage_q <= '0;
      res_status_q <= 1'b1;
    end else if (cmd_i.set_hit) begin
      res_fault_q  <= 1'b0;
      res_frame_q  <= hit_fx[FRAME_OUT_W-1:0];
      res_ev_q     <= 1'b0;
      res_evpage_q <= '0;
      res_status_q <= 1'b0;
    end else if (cmd_i.set_nofr) begin
      res_fault_q  <= 1'b1;
      res_frame_q  <= '0;
      res_ev_q     <= 1'b0;
      res_evpage_q <= '0;
      res_status_q <= 1'b0;
    end else if (cmd_i.load) begin
      res_fault_q  <= 1'b1;
      res_frame_q  <= sel_fx[FRAME_OUT_W-1:0];
      res_ev_q     <= ev_q;
      res_evpage_q <= ev_q ? victim_vx[EVPAGE_W-1:0] : '0;
      res_status_q <= 1'b0;
    end
    if (cmd_i.push) begin
      out_data_q <= {{M_PAD_W{1'b0}}, res_status_q, res_evpage_q, res_ev_q,
                     res_frame_q, res_fault_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= pf_mem[rd_addr];
    end
    if (cmd_i.load) begin
      pf_mem[page_idx]     <= frame_sel;
      owner_mem[frame_sel] <= pid_q;
    end
  end

endmodule

/* sv/demand_paging_frame_replacer.sv */
// Top level of the demand-paging frame replacer: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// Each word on the s_axis channel is one page access (tdata[7:0] = page number).
// Each accepted word yields exactly one m_axis word with the access result.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i while idle:
// index 0 page count, 1 frame count, 2 owner process id.
// A hit or an out-of-range page goes from lookup straight to the response.
// A fault with a free frame adds the eight-index scan up to the free frame and
// the load; a fault that evicts adds the victim scan over the page table plus the
// page-frame memory read. The eight-lane circular scan unit sets these steps.
// One access is in work at a time; s_axis_tready is high only when the block is
// idle, and a new word is taken while the previous result still waits.
// If the receiver stalls m_axis_tready, the result is held in the output register
// and the block waits before pushing the next result.
// Reset clears the page valid bits, frame busy bits, counters and pointers and
// restores the default register values; no clearing pass is needed.
module demand_paging_frame_replacer #(
  parameter int MAX_PAGES  = dpfr_pkg::DEF_MAX_PAGES,
  parameter int MAX_FRAMES = dpfr_pkg::DEF_MAX_FRAMES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dpfr_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [7:0] page_number
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] fault, [6:1] frame, [7] evicted, [15:8] evicted_page, [16] status, rest zero
  output logic [dpfr_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpfr_pkg::*;

  dpfr_cmd_t  cmd;
  dpfr_stat_t stat;

  dpfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpfr_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* tb/sv/tb_demand_paging_frame_replacer.sv */
// Self-checking testbench for the demand-paging frame replacer: stream driver, predictor, monitor.
`timescale 1ns / 1ps

module tb_demand_paging_frame_replacer;
  import dpfr_pkg::*;

  typedef struct packed {
    logic                 status;
    logic [EVPAGE_W-1:0]  evicted_page;
    logic                 evicted;
    logic [FRAME_OUT_W-1:0] frame;
    logic                 fault;
  } access_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_PAGE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [PAGE_W-1:0]   pending_pages[$];
  access_result_t      expected_results[$];
  int                  mismatches = 0;
  bit                  src_gaps = 1'b1;
  bit                  sink_gaps = 1'b1;

  // mirror of the block's registers and tables
  int unsigned         page_limit = PAGE_COUNT_RST;
  int unsigned         frame_limit = FRAME_COUNT_RST;
  logic [PID_W-1:0]    owner_id = PID_RST;
  bit                  page_resident[DEF_MAX_PAGES];
  logic [FRAME_OUT_W-1:0] page_slot[DEF_MAX_PAGES];
  bit                  slot_taken[DEF_MAX_FRAMES];
  logic [PID_W-1:0]    slot_owner[DEF_MAX_FRAMES];
  int unsigned         slots_in_use = 0;
  int unsigned         free_cursor = 0;
  int unsigned         evict_cursor = 0;

  demand_paging_frame_replacer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] page_number
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] fault, [6:1] frame, [7] evicted, [15:8] evicted_page,
                                     // [16] status
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned eff_pages();
    if (page_limit == 0) return 1;
    if (page_limit > DEF_MAX_PAGES) return DEF_MAX_PAGES;
    return page_limit;
  endfunction

  function automatic int unsigned eff_frames();
    if (frame_limit == 0) return 1;
    if (frame_limit > DEF_MAX_FRAMES) return DEF_MAX_FRAMES;
    return frame_limit;
  endfunction

  function automatic access_result_t resolve_access(input logic [PAGE_W-1:0] page);
    access_result_t r;
    int unsigned np, nf, fr, victim, i, tries, idx;
    bit got, ev;
    r = '0;
    np = eff_pages();
    nf = eff_frames();
    fr = 0;
    victim = 0;
    got = 1'b0;
    ev = 1'b0;
    if (page >= np) begin
      r.status = 1'b1;
      return r;
    end
    if (page_resident[page]) begin
      r.frame = page_slot[page];
      return r;
    end
    r.fault = 1'b1;
    if (slots_in_use < nf) begin
      if (free_cursor >= nf) free_cursor = 0;
      for (i = free_cursor; i < nf && !got; i++) begin
        if (!slot_taken[i]) begin
          fr = i;
          got = 1'b1;
        end
      end
      for (i = 0; i < free_cursor && !got; i++) begin
        if (!slot_taken[i]) begin
          fr = i;
          got = 1'b1;
        end
      end
      if (got) free_cursor = fr + 1;
    end
    if (!got) begin
      if (evict_cursor >= np) evict_cursor = 0;
      for (tries = 0; tries < np && !ev; tries++) begin
        idx = evict_cursor;
        evict_cursor = (evict_cursor + 1) % np;
        if (page_resident[idx]) begin
          victim = idx;
          ev = 1'b1;
        end
      end
      if (ev) begin
        fr = page_slot[victim];
        slot_taken[fr] = 1'b0;
        if (slots_in_use > 0) slots_in_use--;
        page_resident[victim] = 1'b0;
        got = 1'b1;
      end
    end
    if (got) begin
      page_slot[page] = fr[FRAME_OUT_W-1:0];
      page_resident[page] = 1'b1;
      slot_taken[fr] = 1'b1;
      slot_owner[fr] = owner_id;
      slots_in_use++;
      r.frame = fr[FRAME_OUT_W-1:0];
    end
    if (ev) begin
      r.evicted = 1'b1;
      r.evicted_page = victim[EVPAGE_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (pending_pages.size() != 0 && !(src_gaps && $urandom_range(99) < 12)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_pages.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_results.push_back(resolve_access(s_axis_tdata));
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t exp_r, act_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = access_result_t'(m_axis_tdata[16:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("fault", exp_r.fault, act_r.fault);
          check_field("frame", exp_r.frame, act_r.frame);
          check_field("evicted", exp_r.evicted, act_r.evicted);
          check_field("evicted_page", exp_r.evicted_page, act_r.evicted_page);
          check_field("status", exp_r.status, act_r.status);
        end
      end
      m_axis_tready <= !(sink_gaps && $urandom_range(99) < 12);
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (pending_pages.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PAGE_COUNT:  page_limit = value;
      CFG_FRAME_COUNT: frame_limit = value[FRAME_COUNT_W-1:0];
      CFG_PROCESS_ID:  owner_id = value[PID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned pages, input int unsigned frames,
                           input int unsigned pid);
    write_reg(CFG_PAGE_COUNT, pages[CFG_DATA_W-1:0]);
    write_reg(CFG_FRAME_COUNT, frames[CFG_DATA_W-1:0]);
    write_reg(CFG_PROCESS_ID, pid[CFG_DATA_W-1:0]);
  endtask

  // mostly a sliding working set of up to a little over twice the frame pool, some raw noise
  task automatic queue_working_set(input int n);
    int unsigned np, nf, span, base;
    np = eff_pages();
    nf = eff_frames();
    span = $urandom_range(1, 2 * nf + 2);
    base = $urandom_range(np - 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) begin
        pending_pages.push_back(PAGE_W'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 5) base = $urandom_range(np - 1);
        pending_pages.push_back(PAGE_W'((base + $urandom_range(span)) % np));
      end
    end
  endtask

  initial begin
    int unsigned pages, frames;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_pages = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd128};
    drain();

    configure(8, 2, 255);
    pending_pages = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd8, 8'd255, 8'd7, 8'd2, 8'd7};
    drain();

    configure(0, 0, 0);
    pending_pages = '{8'd0, 8'd0, 8'd1, 8'd0};
    drain();

    configure(16, 2, 85);
    pending_pages = '{8'd10, 8'd11, 8'd10};
    drain();
    write_reg(CFG_PAGE_COUNT, 9'd4);
    pending_pages = '{8'd0, 8'd3, 8'd4};
    drain();

    configure(300, 100, 170);
    pending_pages = '{8'd255, 8'd10};
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(5))
        0: pages = 1;
        1: pages = 256;
        2: pages = $urandom_range(2, 16);
        3: pages = $urandom_range(17, 255);
        4: pages = ($urandom_range(1) != 0) ? 0 : $urandom_range(257, 511);
        default: pages = $urandom_range(2, 64);
      endcase
      case ($urandom_range(4))
        0: frames = 1;
        1: frames = 64;
        2: frames = $urandom_range(2, 8);
        3: frames = ($urandom_range(1) != 0) ? 0 : $urandom_range(65, 127);
        default: frames = $urandom_range(2, 63);
      endcase
      configure(pages, frames, $urandom_range(255));
      src_gaps = (ph != 5);
      sink_gaps = (ph != 5);
      queue_working_set(75);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
sv/dpfr_pkg.sv
sv/dpfr_ctrl.sv
sv/dpfr_dp.sv
sv/demand_paging_frame_replacer.sv
tb/sv/tb_demand_paging_frame_replacer.sv
